// File: hw/rtl/cas_pkg.sv
package cas_pkg;

  // Table geometry
  localparam int CAPACITY   = 1024;
  localparam int ADDR_W     = $clog2(CAPACITY);
  localparam int COUNT_W    = ADDR_W + 1;
  localparam int CELL_SIZE  = 2;

  // Coordinate and register widths
  localparam int COORD_W    = 12;
  localparam int ROW_W      = 13;
  localparam int REG_W      = 13;
  localparam int COLOR_W    = 32;
  localparam int COORD_LIMIT = 4096;

  // Register indexes
  localparam int CFG_IDX_W  = 1;
  localparam logic [CFG_IDX_W-1:0] REG_ATLAS_WIDTH  = 1'd0;
  localparam logic [CFG_IDX_W-1:0] REG_ATLAS_HEIGHT = 1'd1;

  localparam logic [REG_W-1:0] ATLAS_WIDTH_RESET  = 13'd64;
  localparam logic [REG_W-1:0] ATLAS_HEIGHT_RESET = 13'd64;

  // Request kinds
  localparam logic KIND_MAP     = 1'b0;
  localparam logic KIND_RESERVE = 1'b1;

  // One stored color entry
  typedef struct packed {
    logic [COLOR_W-1:0] color;
    logic [COORD_W-1:0] x;
    logic [COORD_W-1:0] y;
    logic               pre;
  } entry_t;

  // Scan start from the control side
  typedef struct packed {
    logic               start;
    logic [COLOR_W-1:0] color;
    logic [COUNT_W-1:0] count;
  } scan_req_t;

  // Table write from the control side
  typedef struct packed {
    logic              we;
    logic [ADDR_W-1:0] addr;
    entry_t            data;
  } table_wr_t;

  // Scan outcome: first match in each palette
  typedef struct packed {
    logic               done;
    logic               hit_pre;
    logic [COORD_W-1:0] pre_x;
    logic [COORD_W-1:0] pre_y;
    logic               hit_ord;
    logic [COORD_W-1:0] ord_x;
    logic [COORD_W-1:0] ord_y;
  } scan_rsp_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_WAIT
  } state_t;

endpackage

// File: hw/rtl/cas_req_if.sv
interface cas_req_if;
  import cas_pkg::*;

  logic               valid;
  logic               ready;
  logic               kind;
  logic [COLOR_W-1:0] color;

  modport source (output valid, output kind, output color, input ready);
  modport sink   (input valid, input kind, input color, output ready);
endinterface

// File: hw/rtl/cas_res_if.sv
interface cas_res_if;
  import cas_pkg::*;

  logic               valid;
  logic               ready;
  logic [COORD_W-1:0] slot_x;
  logic [COORD_W-1:0] slot_y;
  logic               is_new;
  logic               full_res;

  modport source (output valid, output slot_x, output slot_y, output is_new,
                  output full_res, input ready);
  modport sink   (input valid, input slot_x, input slot_y, input is_new,
                  input full_res, output ready);
endinterface

// File: hw/rtl/cas_table.sv
module cas_table
  import cas_pkg::*;
(
  input  logic      clk,
  input  logic      rst,
  input  scan_req_t scan_req,
  input  table_wr_t wr,
  output scan_rsp_t scan_rsp
);

  entry_t             mem [CAPACITY];
  entry_t             rd_data;
  logic [COUNT_W-1:0] rd_addr;
  logic [COUNT_W-1:0] count;
  logic [COLOR_W-1:0] key;
  logic               active;
  logic               pend;
  logic               rd_en;
  logic               scan_done;

  logic               hit_pre;
  logic [COORD_W-1:0] pre_x;
  logic [COORD_W-1:0] pre_y;
  logic               hit_ord;
  logic [COORD_W-1:0] ord_x;
  logic [COORD_W-1:0] ord_y;

  // Issue one read per cycle until every stored entry has been fetched
  assign rd_en     = active && (rd_addr != count);
  assign scan_done = active && (rd_addr == count) && !pend;

  // Memory: one write port, one registered read port
  always_ff @(posedge clk) begin
    if (wr.we) begin
      mem[wr.addr] <= wr.data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr[ADDR_W-1:0]];
    end
  end

  // Scan control
  always_ff @(posedge clk) begin
    if (rst) begin
      active  <= 1'b0;
      pend    <= 1'b0;
      rd_addr <= '0;
    end else begin
      pend <= rd_en;
      if (scan_req.start) begin
        active  <= 1'b1;
        rd_addr <= '0;
      end else begin
        if (rd_en) begin
          rd_addr <= rd_addr + COUNT_W'(1);
        end
        if (scan_done) begin
          active <= 1'b0;
        end
      end
    end
  end

  // Latch key and count at start; keep the first match of each palette
  always_ff @(posedge clk) begin
    if (scan_req.start) begin
      key     <= scan_req.color;
      count   <= scan_req.count;
      hit_pre <= 1'b0;
      hit_ord <= 1'b0;
    end else if (pend && (rd_data.color == key)) begin
      if (rd_data.pre && !hit_pre) begin
        hit_pre <= 1'b1;
        pre_x   <= rd_data.x;
        pre_y   <= rd_data.y;
      end
      if (!rd_data.pre && !hit_ord) begin
        hit_ord <= 1'b1;
        ord_x   <= rd_data.x;
        ord_y   <= rd_data.y;
      end
    end
  end

  assign scan_rsp.done    = scan_done;
  assign scan_rsp.hit_pre = hit_pre;
  assign scan_rsp.pre_x   = pre_x;
  assign scan_rsp.pre_y   = pre_y;
  assign scan_rsp.hit_ord = hit_ord;
  assign scan_rsp.ord_x   = ord_x;
  assign scan_rsp.ord_y   = ord_y;

endmodule

// File: hw/rtl/color_atlas_slot_allocator_core.sv
// Color atlas slot allocator.
// Request channel (req): kind and a 32-bit RGBA color. Kind map looks in the
// predefined palette, then the ordinary one, and allocates an ordinary entry
// if absent; kind reserve looks and allocates in the predefined palette only.
// Result channel (res): corner of the color's 2x2 cell, is_new when a cell
// was taken, full_res when the table or the atlas had no room.
// Configuration: cfg_we with cfg_index 0 (atlas width) or 1 (atlas height),
// to be written only while no request is in flight; the block does not enforce it.
// Timing: one request at a time. The table scan reads one stored entry per
// cycle through the single read port of the entry memory, so the time from
// transfer in to result valid grows with the number of stored entries, at
// most a full table of 1024 entries. The next request is taken the cycle
// after the result is loaded. The result sits in an output register; a new
// request is taken while it waits. If the receiver stalls, the next scan
// finishes and then holds its outcome until the output register frees.
// Reset empties the table (entry count zero), homes the cursor to 0,0 and
// sets width and height to 64. The memory itself is not cleared.
module color_atlas_slot_allocator_core
  import cas_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst,
  cas_req_if.sink              req,
  cas_res_if.source            res,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [REG_W-1:0]     cfg_data
);

  state_t state, state_next;

  logic [REG_W-1:0]   atlas_width;
  logic [REG_W-1:0]   atlas_height;
  logic [COUNT_W-1:0] entry_count;
  logic [COORD_W-1:0] cursor_col;
  logic [ROW_W-1:0]   cursor_row;

  logic               kind;
  logic [COLOR_W-1:0] color;

  logic               res_valid;
  logic [COORD_W-1:0] slot_x;
  logic [COORD_W-1:0] slot_y;
  logic               is_new;
  logic               full_res;

  scan_req_t scan_req;
  scan_rsp_t scan_rsp;
  table_wr_t wr;

  logic               req_xfer;
  logic               res_xfer;
  logic               out_free;
  logic               decide;
  logic               commit;
  logic               hit;
  logic [COORD_W-1:0] hit_x;
  logic [COORD_W-1:0] hit_y;
  logic               no_room;
  logic               alloc;
  logic [REG_W-1:0]   eff_w;
  logic [REG_W-1:0]   eff_h;
  logic [ROW_W:0]     row_end;
  logic [COORD_W:0]   next_col;

  cas_table u_table (
    .clk      (clk),
    .rst      (rst),
    .scan_req (scan_req),
    .wr       (wr),
    .scan_rsp (scan_rsp)
  );

  assign req_xfer = req.valid && req.ready;
  assign res_xfer = res_valid && res.ready;
  assign out_free = !res_valid || res.ready;

  // Next state
  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (req_xfer) state_next = ST_SCAN;
      end
      ST_SCAN: begin
        if (scan_rsp.done) state_next = out_free ? ST_IDLE : ST_WAIT;
      end
      ST_WAIT: begin
        if (out_free) state_next = ST_IDLE;
      end
      default: state_next = ST_IDLE;
    endcase
  end

  // State outputs
  always_comb begin
    req.ready = 1'b0;
    decide    = 1'b0;
    case (state)
      ST_IDLE: req.ready = 1'b1;
      ST_SCAN: decide    = scan_rsp.done;
      ST_WAIT: decide    = 1'b1;
      default: begin
        req.ready = 1'b0;
        decide    = 1'b0;
      end
    endcase
  end

  assign commit = decide && out_free;

  // Start the scan on request transfer
  assign scan_req.start = req_xfer;
  assign scan_req.color = req.color;
  assign scan_req.count = entry_count;

  // Resolve lookup: predefined first, ordinary only for map requests
  always_comb begin
    hit   = scan_rsp.hit_pre || ((kind == KIND_MAP) && scan_rsp.hit_ord);
    hit_x = scan_rsp.hit_pre ? scan_rsp.pre_x : scan_rsp.ord_x;
    hit_y = scan_rsp.hit_pre ? scan_rsp.pre_y : scan_rsp.ord_y;
  end

  // Clamp atlas size to the coordinate range and check for room
  always_comb begin
    eff_w    = (atlas_width  > REG_W'(COORD_LIMIT)) ? REG_W'(COORD_LIMIT) : atlas_width;
    eff_h    = (atlas_height > REG_W'(COORD_LIMIT)) ? REG_W'(COORD_LIMIT) : atlas_height;
    row_end  = {1'b0, cursor_row} + (ROW_W+1)'(CELL_SIZE);
    next_col = {1'b0, cursor_col} + (COORD_W+1)'(CELL_SIZE);
    no_room  = (entry_count >= COUNT_W'(CAPACITY)) || (row_end > {1'b0, eff_h});
    alloc    = !hit && !no_room;
  end

  // Store the new entry at the end of the table
  assign wr.we         = commit && alloc;
  assign wr.addr       = entry_count[ADDR_W-1:0];
  assign wr.data.color = color;
  assign wr.data.x     = cursor_col;
  assign wr.data.y     = cursor_row[COORD_W-1:0];
  assign wr.data.pre   = kind;

  // Control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= ST_IDLE;
      atlas_width  <= ATLAS_WIDTH_RESET;
      atlas_height <= ATLAS_HEIGHT_RESET;
      entry_count  <= '0;
      cursor_col   <= '0;
      cursor_row   <= '0;
      res_valid    <= 1'b0;
    end else begin
      state <= state_next;
      if (cfg_we) begin
        case (cfg_index)
          REG_ATLAS_WIDTH:  atlas_width  <= cfg_data;
          REG_ATLAS_HEIGHT: atlas_height <= cfg_data;
          default: ;
        endcase
      end
      // Advance the cursor, wrap at the atlas width
      if (commit && alloc) begin
        entry_count <= entry_count + COUNT_W'(1);
        if (next_col >= eff_w) begin
          cursor_col <= '0;
          cursor_row <= cursor_row + ROW_W'(CELL_SIZE);
        end else begin
          cursor_col <= next_col[COORD_W-1:0];
        end
      end
      if (commit) begin
        res_valid <= 1'b1;
      end else if (res_xfer) begin
        res_valid <= 1'b0;
      end
    end
  end

  // Hold the request payload for the scan
  always_ff @(posedge clk) begin
    if (req_xfer) begin
      kind  <= req.kind;
      color <= req.color;
    end
  end

  // Load the result register
  always_ff @(posedge clk) begin
    if (commit) begin
      if (hit) begin
        slot_x   <= hit_x;
        slot_y   <= hit_y;
        is_new   <= 1'b0;
        full_res <= 1'b0;
      end else if (no_room) begin
        slot_x   <= '0;
        slot_y   <= '0;
        is_new   <= 1'b0;
        full_res <= 1'b1;
      end else begin
        slot_x   <= cursor_col;
        slot_y   <= cursor_row[COORD_W-1:0];
        is_new   <= 1'b1;
        full_res <= 1'b0;
      end
    end
  end

  assign res.valid    = res_valid;
  assign res.slot_x   = slot_x;
  assign res.slot_y   = slot_y;
  assign res.is_new   = is_new;
  assign res.full_res = full_res;

endmodule
